// ----- hw/rtl/ier_pkg.sv -----
// ier_pkg: shared types, constants and the one's-complement add helper
// for the icmp echo responder; no dependencies
package ier_pkg;

    // icmp codes and header positions
    localparam logic [7:0] ECHO_REQUEST  = 8'd8;
    localparam logic [3:0] POS_TYPE      = 4'd0;
    localparam logic [3:0] POS_CODE      = 4'd1;
    localparam logic [3:0] POS_CSUM_HI   = 4'd2;
    localparam logic [3:0] POS_CSUM_LO   = 4'd3;
    localparam logic [3:0] POS_LAST_HDR  = 4'd7;
    localparam logic [3:0] POS_SAT       = 4'd8;

    // one queued reply request: one or two reply bytes
    typedef struct packed {
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic        two_bytes;
        logic        last;
        logic        ok;
        logic [31:0] addr;
    } reply_entry_t;

    // one's-complement 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

// ----- hw/rtl/ier_in_if.sv -----
// ier_in_if: request channel carrying icmp message bytes
// no dependencies
interface ier_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_byte;
    logic        end_of_message;
    logic [31:0] source_addr;

    modport source (output valid, output msg_byte, output end_of_message,
                    output source_addr, input ready);
    modport sink   (input valid, input msg_byte, input end_of_message,
                    input source_addr, output ready);
endinterface

// ----- hw/rtl/ier_out_if.sv -----
// ier_out_if: reply channel carrying echo reply bytes
// no dependencies
interface ier_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        send_ok;
    logic [31:0] reply_addr;

    modport source (output valid, output out_byte, output out_last,
                    output send_ok, output reply_addr, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input send_ok, input reply_addr, output ready);
endinterface

// ----- hw/rtl/ier_front.sv -----
// ier_front: accepts message bytes, runs the checksum and header tracking,
// and pushes reply requests into the queue; depends on ier_pkg, ier_in_if
module ier_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    ier_in_if.sink                msg,
    input  logic                  queue_full,
    output logic                  push,
    output ier_pkg::reply_entry_t push_entry
);

    logic [3:0]  header_pos_reg, header_pos_next;
    logic        odd_phase_reg, odd_phase_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] running_reg, running_next;
    logic [15:0] received_reg, received_next;
    logic        echo_reg, echo_next;
    logic [31:0] addr_reg, addr_next;

    logic        accept;
    logic        echo_cur;
    logic [15:0] word_sum;
    logic [15:0] running_upd;
    logic [15:0] received_upd;
    logic [15:0] pad_sum;
    logic [15:0] final_sum;
    logic [15:0] reply_csum;
    logic        csum_ok;
    logic [1:0]  n_out;
    logic [3:0]  p;

    assign msg.ready = !queue_full;
    assign accept    = msg.valid && msg.ready;
    assign p         = header_pos_reg;

    // classification and checksum datapath
    always_comb
    begin
        echo_cur  = (p == ier_pkg::POS_TYPE) ? (msg.msg_byte == ier_pkg::ECHO_REQUEST)
                                              : echo_reg;
        addr_next = (p == ier_pkg::POS_TYPE) ? msg.source_addr : addr_reg;
        word_sum  = ier_pkg::oc_add(running_reg, {held_reg, msg.msg_byte});
        pad_sum   = ier_pkg::oc_add(running_reg, {msg.msg_byte, 8'h00});

        running_upd = (odd_phase_reg && (p != ier_pkg::POS_CSUM_LO)) ? word_sum
                                                                     : running_reg;

        if (p == ier_pkg::POS_CSUM_HI)
        begin
            received_upd = {msg.msg_byte, 8'h00};
        end
        else if (p == ier_pkg::POS_CSUM_LO)
        begin
            received_upd = {received_reg[15:8], msg.msg_byte};
        end
        else
        begin
            received_upd = received_reg;
        end

        // odd length ends with a zero-padded high byte
        final_sum = odd_phase_reg ? running_upd : pad_sum;
        csum_ok   = (p >= ier_pkg::POS_LAST_HDR) && ((~final_sum) == received_upd);

        // incremental update with type/code replaced by zero
        reply_csum = ~ier_pkg::oc_add(~received_upd, ~running_reg);

        // number of reply bytes for this request
        if (!echo_cur)
        begin
            n_out = 2'd0;
        end
        else if (p == ier_pkg::POS_TYPE || p == ier_pkg::POS_CODE)
        begin
            n_out = 2'd1;
        end
        else if (p == ier_pkg::POS_CSUM_HI)
        begin
            n_out = msg.end_of_message ? 2'd1 : 2'd0;
        end
        else if (p == ier_pkg::POS_CSUM_LO)
        begin
            n_out = 2'd2;
        end
        else
        begin
            n_out = 2'd1;
        end
    end

    // queue entry
    always_comb
    begin
        push                   = accept && (n_out != 2'd0);
        push_entry.first_byte  = (p == ier_pkg::POS_CSUM_LO) ? reply_csum[15:8]
                               : (p < ier_pkg::POS_CSUM_LO)  ? 8'h00
                                                             : msg.msg_byte;
        push_entry.second_byte = reply_csum[7:0];
        push_entry.two_bytes   = (n_out == 2'd2);
        push_entry.last        = msg.end_of_message;
        push_entry.ok          = msg.end_of_message && csum_ok;
        push_entry.addr        = addr_next;
    end

    // per-message state update
    always_comb
    begin
        header_pos_next = header_pos_reg;
        odd_phase_next  = odd_phase_reg;
        held_next       = held_reg;
        running_next    = running_reg;
        received_next   = received_reg;
        echo_next       = echo_reg;
        if (accept)
        begin
            if (msg.end_of_message)
            begin
                header_pos_next = 4'd0;
                odd_phase_next  = 1'b0;
                held_next       = 8'h00;
                running_next    = 16'h0000;
                received_next   = 16'h0000;
                echo_next       = 1'b0;
            end
            else
            begin
                header_pos_next = (header_pos_reg < ier_pkg::POS_SAT) ? header_pos_reg + 4'd1
                                                                      : header_pos_reg;
                odd_phase_next  = !odd_phase_reg;
                held_next       = odd_phase_reg ? held_reg : msg.msg_byte;
                running_next    = running_upd;
                received_next   = received_upd;
                echo_next       = echo_cur;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg <= 4'd0;
            odd_phase_reg  <= 1'b0;
            held_reg       <= 8'h00;
            running_reg    <= 16'h0000;
            received_reg   <= 16'h0000;
            echo_reg       <= 1'b0;
            addr_reg       <= 32'd0;
        end
        else
        begin
            header_pos_reg <= header_pos_next;
            odd_phase_reg  <= odd_phase_next;
            held_reg       <= held_next;
            running_reg    <= running_next;
            received_reg   <= received_next;
            echo_reg       <= echo_next;
            if (accept)
            begin
                addr_reg <= addr_next;
            end
        end
    end

endmodule

// ----- hw/rtl/ier_queue.sv -----
// ier_queue: small fifo of reply requests between front and back
// depends on ier_pkg
module ier_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ier_pkg::reply_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output ier_pkg::reply_entry_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ier_pkg::reply_entry_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/ier_back.sv -----
// ier_back: drains reply requests and streams reply bytes through an
// output register; depends on ier_pkg, ier_out_if
module ier_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  ier_pkg::reply_entry_t head,
    output logic                  pop,
    ier_out_if.source             reply
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        ok_reg, ok_next;
    logic [31:0] addr_reg;
    logic        load;
    logic        split_first;

    assign reply.valid      = valid_reg;
    assign reply.out_byte   = byte_reg;
    assign reply.out_last   = last_reg;
    assign reply.send_ok    = ok_reg;
    assign reply.reply_addr = addr_reg;

    assign load        = !valid_reg || reply.ready;
    assign split_first = head.two_bytes && !phase_reg;

    // pick the next reply byte from the queue head
    always_comb
    begin
        pop        = 1'b0;
        valid_next = valid_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        ok_next    = ok_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (split_first)
                begin
                    byte_next  = head.first_byte;
                    last_next  = 1'b0;
                    ok_next    = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    byte_next  = head.two_bytes ? head.second_byte : head.first_byte;
                    last_next  = head.last;
                    ok_next    = head.ok;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        ok_reg   <= ok_next;
        if (load && !empty)
        begin
            addr_reg <= head.addr;
        end
    end

endmodule

// ----- hw/rtl/icmp_echo_responder.sv -----
// icmp_echo_responder: top level, front classifier, request queue and
// reply streamer; depends on ier_pkg, ier_in_if, ier_out_if, ier_front,
// ier_queue, ier_back
//
//   channel  dir  payload                                      request
//   msg      in   msg_byte, end_of_message, source_addr        one message byte
//   reply    out  out_byte, out_last, send_ok, reply_addr      one reply byte
//
// one message byte is taken each cycle while the queue has room; each reply
// byte leaves the output register one per cycle while reply.ready is high, so
// the checksum pair leaves as two reply bytes and the queue absorbs that while byte 2 gives none.
// reply bytes enter the queue as their request byte is accepted, then the output register.
// rst_n clears header tracking, sums, queue pointers and output valid.
// a stalled reply side fills the queue, then msg.ready drops.
module icmp_echo_responder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    ier_in_if.sink    msg,
    ier_out_if.source reply
);

    ier_pkg::reply_entry_t push_entry;
    ier_pkg::reply_entry_t head;
    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;

    // classify bytes and build reply requests
    ier_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouple front and back
    ier_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    // stream reply bytes
    ier_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .reply (reply)
    );

endmodule

// ----- dv/tb_icmp_echo_responder.sv -----
// tb_icmp_echo_responder: self-checking testbench for the icmp echo responder
// depends on ier_pkg, ier_in_if, ier_out_if and the icmp_echo_responder rtl
// reply bytes are predicted per request byte and every reply byte is compared
`timescale 1ns / 100ps

module tb_icmp_echo_responder;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ECHO_BYTE_TARGET = 700;

    // one expected reply byte
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        ok;
        logic [31:0] addr;
    } reply_byte_t;

    typedef logic [7:0] msg_bytes_t[$];

    logic clk;
    logic rst_n;

    ier_in_if  msg_if();
    ier_out_if reply_if();

    icmp_echo_responder DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .reply (reply_if)
    );

    // predictor state, zero at start
    logic [3:0]  hdr_pos  = '0;
    logic        odd_byte = 1'b0;
    logic [7:0]  held_hi  = '0;
    logic [15:0] word_sum = '0;
    logic [15:0] rx_csum  = '0;
    logic        is_echo  = 1'b0;
    logic [31:0] req_addr = '0;

    reply_byte_t pending_replies[$];

    int errors = 0;
    int cycles = 0;
    int stall_left = 0;
    int seen_replies = 0;
    bit sender_idles;
    bit receiver_stalls;
    int msgs_sent;
    int echo_msgs;
    int echo_bytes;
    int replies_checked = 0;

    always #1 clk = ~clk;

    // one's-complement 16-bit sum with end-around carry
    function automatic logic [15:0] ones_sum(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] wide;
        wide = x + y;
        return wide[15:0] + wide[16];
    endfunction

    // advance the predictor by one accepted message byte
    function automatic void predict_reply(input logic [7:0] b, input logic eom,
                                          input logic [31:0] a);
        logic [3:0]  p;
        logic [15:0] t;
        logic [15:0] hc;
        logic [15:0] total;
        logic        ok;
        reply_byte_t step_q[$];
        reply_byte_t r;
        p = hdr_pos;
        if (p == ier_pkg::POS_TYPE)
        begin
            req_addr = a;
            is_echo  = (b == ier_pkg::ECHO_REQUEST);
        end
        // pair bytes into words, the checksum word is left out
        if (!odd_byte)
            held_hi = b;
        else if (p != ier_pkg::POS_CSUM_LO)
            word_sum = ones_sum(word_sum, {held_hi, b});
        odd_byte = ~odd_byte;
        if (p == ier_pkg::POS_CSUM_HI)
            rx_csum = {b, 8'h00};
        else if (p == ier_pkg::POS_CSUM_LO)
            rx_csum = rx_csum | {8'h00, b};
        // reply bytes caused by this request
        r = '0;
        r.addr = req_addr;
        if (is_echo)
        begin
            if (p == ier_pkg::POS_TYPE || p == ier_pkg::POS_CODE)
            begin
                r.data = 8'h00;
                step_q.push_back(r);
            end
            else if (p == ier_pkg::POS_CSUM_HI)
            begin
                if (eom)
                begin
                    r.data = 8'h00;
                    step_q.push_back(r);
                end
            end
            else if (p == ier_pkg::POS_CSUM_LO)
            begin
                // incremental update with the type/code word going to zero
                t  = ones_sum(~rx_csum, ~word_sum);
                hc = ~t;
                r.data = hc[15:8];
                step_q.push_back(r);
                r.data = hc[7:0];
                step_q.push_back(r);
            end
            else
            begin
                r.data = b;
                step_q.push_back(r);
            end
        end
        if (hdr_pos < ier_pkg::POS_SAT)
            hdr_pos = hdr_pos + 4'd1;
        // end of message: verify checksum, pad an odd trailing byte
        if (eom)
        begin
            total = word_sum;
            if (odd_byte)
                total = ones_sum(total, {held_hi, 8'h00});
            ok = (p >= ier_pkg::POS_LAST_HDR) && ((~total) == rx_csum);
            if (step_q.size() > 0)
            begin
                step_q[step_q.size() - 1].last = 1'b1;
                step_q[step_q.size() - 1].ok   = ok;
            end
            hdr_pos  = '0;
            odd_byte = 1'b0;
            held_hi  = '0;
            word_sum = '0;
            rx_csum  = '0;
            is_echo  = 1'b0;
        end
        foreach (step_q[i])
            pending_replies.push_back(step_q[i]);
    endfunction

    // fill in a correct checksum over the bytes present
    function automatic msg_bytes_t with_checksum(input msg_bytes_t m);
        logic [15:0] s;
        s = '0;
        for (int i = 0; i < m.size(); i += 2)
        begin
            if (i != 2)
                s = ones_sum(s, {m[i], (i + 1 < m.size()) ? m[i + 1] : 8'h00});
        end
        s = ~s;
        if (m.size() > 2)
            m[2] = s[15:8];
        if (m.size() > 3)
            m[3] = s[7:0];
        return m;
    endfunction

    // echo request with random code and content and a correct checksum
    function automatic msg_bytes_t random_echo(input int len);
        msg_bytes_t m;
        for (int i = 0; i < len; i++)
            m.push_back(8'($urandom()));
        m[0] = ier_pkg::ECHO_REQUEST;
        return with_checksum(m);
    endfunction

    // drive one message byte and wait for its handshake
    task automatic send_byte(input logic [7:0] b, input logic eom, input logic [31:0] a);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.msg_byte       <= b;
        msg_if.end_of_message <= eom;
        msg_if.source_addr    <= a;
        do
            @(posedge clk);
        while (!msg_if.ready);
        predict_reply(b, eom, a);
    endtask

    // send a whole message; later bytes carry a random address that must be ignored
    task automatic send_message(input msg_bytes_t m, input logic [31:0] a);
        msgs_sent++;
        if (m[0] == ier_pkg::ECHO_REQUEST)
        begin
            echo_msgs++;
            echo_bytes += m.size();
        end
        for (int i = 0; i < m.size(); i++)
            send_byte(m[i], i == m.size() - 1, (i == 0) ? a : $urandom());
    endtask

    // hold the sender idle until every expected reply byte has arrived
    task automatic drain_replies();
        @(negedge clk);
        msg_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_odd_length_extremes();
        msg_bytes_t m;
        // id and payload all ones, odd trailing byte padded with zero
        m = {ier_pkg::ECHO_REQUEST, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00,
             8'hff};
        send_message(with_checksum(m), 32'hffff_ffff);
        drain_replies();
    endtask

    task automatic test_zero_reply_checksum();
        msg_bytes_t m;
        // id, sequence and payload sum to zero, reply checksum comes out 0x0000
        m = {ier_pkg::ECHO_REQUEST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_message(with_checksum(m), 32'h0000_0000);
        drain_replies();
    endtask

    task automatic test_bad_checksum();
        msg_bytes_t m;
        m = random_echo(8);
        m[5] = m[5] ^ 8'h01;
        send_message(m, $urandom());
        drain_replies();
    endtask

    task automatic test_early_end();
        msg_bytes_t m;
        // end on the type byte, then on the first checksum byte
        m = {ier_pkg::ECHO_REQUEST};
        send_message(m, $urandom());
        m = {ier_pkg::ECHO_REQUEST, 8'h00, 8'h5a};
        send_message(m, $urandom());
        drain_replies();
    endtask

    task automatic test_other_types();
        msg_bytes_t m;
        // echo reply and an unknown type give no reply bytes
        m = {8'h00, 8'h00};
        send_message(m, $urandom());
        m = {8'hf7};
        send_message(m, $urandom());
        drain_replies();
    endtask

    task automatic test_random_traffic();
        msg_bytes_t m;
        int kind;
        int len;
        int pos;
        while (echo_bytes < ECHO_BYTE_TARGET)
        begin
            kind = $urandom_range(0, 99);
            // switch idling on and off for stretches
            if ($urandom_range(0, 7) == 0)
                sender_idles = $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0)
                receiver_stalls = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(17, 40);
            else
                len = $urandom_range(8, 16);
            if (kind < 70)
                m = random_echo(len);
            else if (kind < 80)
            begin
                // corrupt one bit anywhere past the type byte
                m = random_echo(len);
                pos = $urandom_range(1, len - 1);
                m[pos] = m[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (kind < 90)
            begin
                m = random_echo($urandom_range(1, 7));
                if ($urandom_range(0, 1) && m.size() > 3)
                    m[3] = 8'($urandom());
            end
            else
            begin
                m = random_echo($urandom_range(1, 12));
                m[0] = 8'($urandom());
                if (m[0] == ier_pkg::ECHO_REQUEST)
                    m[0] = 8'h00;
            end
            send_message(m, $urandom());
            if ($urandom_range(0, 29) == 0)
                drain_replies();
        end
    endtask

    // reply side stalls, drawn per accepted reply byte
    always @(negedge clk)
    begin
        if (replies_checked != seen_replies)
        begin
            seen_replies = replies_checked;
            stall_left   = receiver_stalls ? $urandom_range(0, 8) : 0;
        end
        if (stall_left > 0)
        begin
            reply_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            reply_if.ready <= 1'b1;
    end

    // compare each accepted reply byte with the oldest expectation
    always @(posedge clk)
    begin
        reply_byte_t want;
        if (rst_n && reply_if.valid && reply_if.ready)
        begin
            replies_checked++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply byte, expected none, got %02h", $time,
                         reply_if.out_byte);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (reply_if.out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h got %02h", $time, want.data,
                             reply_if.out_byte);
                    errors++;
                end
                if (reply_if.out_last !== want.last)
                begin
                    $display("%0t: out_last expected %0b got %0b", $time, want.last,
                             reply_if.out_last);
                    errors++;
                end
                if (reply_if.send_ok !== want.ok)
                begin
                    $display("%0t: send_ok expected %0b got %0b", $time, want.ok,
                             reply_if.send_ok);
                    errors++;
                end
                if (reply_if.reply_addr !== want.addr)
                begin
                    $display("%0t: reply_addr expected %08h got %08h", $time, want.addr,
                             reply_if.reply_addr);
                    errors++;
                end
            end
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reply bytes outstanding", cycles,
                     pending_replies.size());
            $display("tb_icmp_echo_responder: done, errors");
            $finish;
        end
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.msg_byte       = '0;
        msg_if.end_of_message = 1'b0;
        msg_if.source_addr    = '0;
        reply_if.ready        = 1'b0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        msgs_sent       = 0;
        echo_msgs       = 0;
        echo_bytes      = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_odd_length_extremes();
        test_zero_reply_checksum();
        test_bad_checksum();
        test_early_end();
        test_other_types();
        test_random_traffic();

        drain_replies();
        repeat (10) @(posedge clk);

        $display("sent %0d messages (%0d echo requests, %0d echo bytes)", msgs_sent,
                 echo_msgs, echo_bytes);
        $display("checked %0d reply bytes, %0d mismatches", replies_checked, errors);
        if (errors == 0)
            $display("tb_icmp_echo_responder: done, clean");
        else
            $display("tb_icmp_echo_responder: done, errors");
        $finish;
    end

endmodule
